// ----- sv/skt_pkg.sv -----
`timescale 1ns / 1ps

package skt_pkg;

    // Fixed field widths of the item and result beats.
    localparam int KEY_W = 60;
    localparam int POS_W = 11;

    // Operation codes carried on the request channel.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Result status codes.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Sequencer commands to the search unit.
    typedef struct packed {
        logic start;
        logic step;
    } srch_ctrl_t;

    // Search unit report back to the sequencer.
    typedef struct packed {
        logic probe;
        logic finish;
        logic hit;
    } srch_res_t;

endpackage

// ----- sv/skt_ram.sv -----
`timescale 1ns / 1ps

module skt_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/skt_search.sv -----
`timescale 1ns / 1ps

module skt_search #(
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  logic                     clk,
    input  skt_pkg::srch_ctrl_t      ctrl,
    input  logic [CW-1:0]            count,
    input  logic [skt_pkg::KEY_W-1:0] key,
    input  logic [skt_pkg::KEY_W-1:0] rd_data,
    output skt_pkg::srch_res_t       res,
    output logic [AW-1:0]            probe_addr,
    output logic [CW-1:0]            result_pos
);

    import skt_pkg::*;

    // Bounds: lo_reg holds the lower bound, hi_reg the upper bound plus one.
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg;
    logic [CW:0]   mid_sum;
    logic          key_eq;
    logic          key_gt;
    logic          open_span;
    logic          hit_now;

    // One shared compare of the probed key against the search key.
    assign key_eq = (rd_data == key);
    assign key_gt = (rd_data > key);

    // Next bounds: load on start, narrow on each returned probe.
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.start)
        begin
            lo_next = '0;
            hi_next = count;
        end
        else if (ctrl.step && !key_eq)
        begin
            if (key_gt)
            begin
                hi_next = CW'(mid_reg);
            end
            else
            begin
                lo_next = CW'(mid_reg) + CW'(1);
            end
        end
    end

    // Midpoint of the next bounds, which is the next probe address.
    assign mid_sum    = {1'b0, lo_next} + {1'b0, hi_next} - (CW + 1)'(1);
    assign probe_addr = mid_sum[AW:1];
    assign open_span  = (hi_next > lo_next);
    assign hit_now    = ctrl.step && key_eq;

    assign res.hit    = hit_now;
    assign res.probe  = (ctrl.start || ctrl.step) && !hit_now && open_span;
    assign res.finish = (ctrl.start || ctrl.step) && (hit_now || !open_span);
    assign result_pos = hit_now ? CW'(mid_reg) : hi_next;

    // Bound and probe registers.
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (res.probe)
        begin
            mid_reg <= probe_addr;
        end
    end

endmodule

// ----- sv/sorted_key_table_core.sv -----
`timescale 1ns / 1ps

// Lookup: the request is accepted, binary-search probes run (at most clog2(count+1)),
// then the result beat is loaded. Insert adds one shift step per key moved up
// (count - position) and a final write unless full; clear and no-op go to the result.
// Throughput is one item at a time; requests are stalled until the sequencer is idle.
// Reset empties the table at once; the key memory itself is not cleared.
module sorted_key_table_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  skt_pkg::op_t              opcode,
    input  logic [skt_pkg::KEY_W-1:0] key,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic                      found,
    output logic [skt_pkg::POS_W-1:0] position,
    output logic [skt_pkg::POS_W-1:0] entry_count,
    output logic                      status
);

    import skt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PROBE  = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_WRITE  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic            hit_reg, hit_next;
    logic            full_reg, full_next;
    logic [AW-1:0]   wr_idx_reg, wr_idx_next;

    logic            rsp_valid_reg;
    logic            found_reg;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] entry_count_reg;
    logic            status_reg;
    logic            rsp_load;

    srch_ctrl_t      srch_ctrl;
    srch_res_t       srch_res;
    logic [AW-1:0]   srch_addr;
    logic [CW-1:0]   srch_pos;

    logic            shift_rd;
    logic [AW-1:0]   shift_rd_addr;
    logic            ram_we;
    logic [AW-1:0]   ram_wr_addr;
    logic [KEY_W-1:0] ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    logic [KEY_W-1:0] ram_rd_data;

    // Commands to the search unit.
    always_comb
    begin
        srch_ctrl.start = (state_reg == S_IDLE) && req_valid &&
                          ((opcode == OP_INSERT) || (opcode == OP_LOOKUP));
        srch_ctrl.step  = (state_reg == S_PROBE);
    end

    skt_search #(
        .CW(CW),
        .AW(AW)
    ) u_search (
        .clk        (clk),
        .ctrl       (srch_ctrl),
        .count      (count_reg),
        .key        (key_reg),
        .rd_data    (ram_rd_data),
        .res        (srch_res),
        .probe_addr (srch_addr),
        .result_pos (srch_pos)
    );

    // Key store: one write and one registered read per cycle.
    skt_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ram_rd_en   = srch_res.probe || shift_rd;
    assign ram_rd_addr = srch_res.probe ? srch_addr : shift_rd_addr;

    // The result beat is loaded when the output register is free or draining.
    assign rsp_load = (state_reg == S_RESULT) && (!rsp_valid_reg || !rsp_stall);

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        hit_next      = hit_reg;
        full_next     = full_reg;
        wr_idx_next   = wr_idx_reg;
        shift_rd      = 1'b0;
        shift_rd_addr = '0;
        ram_we        = 1'b0;
        ram_wr_addr   = '0;
        ram_wr_data   = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = opcode;
                    key_next  = key;
                    pos_next  = '0;
                    hit_next  = 1'b0;
                    full_next = 1'b0;
                    case (opcode)
                        OP_INSERT, OP_LOOKUP:
                        begin
                            state_next = S_PROBE;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                state_next = S_PROBE;
            end
            S_SHIFT:
            begin
                // Move the key read last cycle up by one place.
                ram_we      = 1'b1;
                ram_wr_addr = wr_idx_reg;
                ram_wr_data = ram_rd_data;
                if (CW'(wr_idx_reg) > pos_reg + CW'(1))
                begin
                    shift_rd      = 1'b1;
                    shift_rd_addr = wr_idx_reg - AW'(2);
                    wr_idx_next   = wr_idx_reg - AW'(1);
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = pos_reg[AW-1:0];
                ram_wr_data = key_reg;
                count_next  = count_reg + CW'(1);
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Search done: decide between result, shift and direct write.
        if (srch_res.finish)
        begin
            pos_next = srch_pos;
            hit_next = srch_res.hit;
            if (op_next == OP_LOOKUP)
            begin
                state_next = S_RESULT;
            end
            else if (count_reg == CW'(TABLE_DEPTH))
            begin
                full_next  = 1'b1;
                state_next = S_RESULT;
            end
            else if (count_reg > srch_pos)
            begin
                shift_rd      = 1'b1;
                shift_rd_addr = AW'(count_reg - CW'(1));
                wr_idx_next   = count_reg[AW-1:0];
                state_next    = S_SHIFT;
            end
            else
            begin
                state_next = S_WRITE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            count_reg <= count_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        hit_reg    <= hit_next;
        full_reg   <= full_next;
        wr_idx_reg <= wr_idx_next;
        if (rsp_load)
        begin
            found_reg       <= (op_reg == OP_LOOKUP) && hit_reg;
            position_reg    <= POS_W'(pos_reg);
            entry_count_reg <= POS_W'(count_reg);
            status_reg      <= full_reg ? ST_FULL : ST_OK;
        end
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("key count exceeds table depth");

    // Every shift write lands above the insertion point.
    a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (CW'(wr_idx_reg) > pos_reg))
        else $error("shift write at or below insertion point");

    // A refused insert is reported only when the table is full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(rsp_valid_reg) && (status_reg == ST_FULL)) |->
        (count_reg == CW'(TABLE_DEPTH)))
        else $error("full status with free entries");

    // An insert that was not refused grows the table by one.
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the key count");

endmodule
